>>> sv/swe_pkg.sv
// Shared types and constants for the sliding-window extreme block.
// No dependencies; imported by swe_cell and sliding_window_extreme_top.
package swe_pkg;

    // Width of the window length register
    localparam int WINDOW_LEN_W = 7;
    // Width of the configuration data and index
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN = 1'b0,
        CFG_SELECT_MIN = 1'b1
    } t_cfg_idx;

    // Tracking mode: window maximum or window minimum
    typedef enum logic {
        MODE_MAX = 1'b0,
        MODE_MIN = 1'b1
    } t_mode;

endpackage

>>> sv/swe_cell.sv
// One cell of the candidate chain: holds one sample and its alive flag.
// Cell IDX holds the sample of age IDX. Depends on swe_pkg.
module swe_cell
    import swe_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int KW           = 7,
    parameter int IDX          = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic                           i_restart,
    input  t_mode                          i_mode,
    input  logic        [KW-1:0]           i_k,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    // link from the younger neighbour
    input  logic signed [SAMPLE_WIDTH-1:0] i_prev_value,
    input  logic                           i_prev_alive,
    input  logic                           i_run,
    // link to the older neighbour
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic                           o_keep,
    output logic                           o_run,
    // front selection, passed from older to younger
    input  logic                           i_older,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sel,
    output logic                           o_older,
    output logic signed [SAMPLE_WIDTH-1:0] o_sel
);

    // Age this entry reaches once the next sample arrives
    localparam logic [KW-1:0] AGE_NEXT = KW'(IDX + 1);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic                           r_alive;

    logic w_expired;
    logic w_alive_eff;
    logic w_beaten;

    // Drop on restart or once the entry leaves the window
    assign w_expired   = (AGE_NEXT >= i_k);
    assign w_alive_eff = r_alive & ~i_restart & ~w_expired;

    // The new sample beats this entry
    assign w_beaten = (i_mode == MODE_MIN) ? (r_value > i_sample) : (r_value < i_sample);

    // Pop run from the back: continues through dead entries and beaten ones
    assign o_run   = i_run & (~w_alive_eff | w_beaten);
    assign o_keep  = w_alive_eff & ~o_run;
    assign o_value = r_value;

    // Front is the oldest alive entry
    assign o_older = i_older | r_alive;
    assign o_sel   = (r_alive && !i_older) ? r_value : i_sel;

    // Advance the chain by one on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else if (i_shift) begin
            r_alive <= i_prev_alive;
        end
    end

    // Sample payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_prev_value;
        end
    end

endmodule

>>> sv/sliding_window_extreme_top.sv
// Sliding-window maximum or minimum over a stream of signed samples.
// The block takes one sample per clock cycle, without stalling on its own: a chain of
// WINDOW_MAX cells shifts by one per sample, so cell i holds the sample of age i, and
// entries that leave the window or are beaten by the new sample are dropped in the same
// cycle through a pop run that ripples across the cells. A due result waits in r_pend
// once the sample is taken; the front value of the updated chain is then loaded into
// the output register once the result channel can take it. Write window_len and
// select_min only while no transaction is in flight. Depends on swe_pkg and swe_cell.
module sliding_window_extreme_top
    import swe_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0]   i_cfg_data,
    // sample channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_restart,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_extreme
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KW    = (CNT_W > WINDOW_LEN_W) ? CNT_W : WINDOW_LEN_W;
    localparam logic [KW-1:0] K_MAX = KW'(WINDOW_MAX);

    logic [WINDOW_LEN_W-1:0] r_window_len;
    t_mode                   r_mode;
    logic [KW-1:0]           r_seen;
    logic [KW-1:0]           n_seen;
    logic                    r_pend;
    logic                    r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_extreme;

    logic [KW-1:0] w_len;
    logic [KW-1:0] w_k;
    logic [KW-1:0] w_seen_base;
    logic          w_accept;
    logic          w_load_ok;
    logic          w_load;
    logic          w_hit;

    // chain links; index j feeds cell j
    logic signed [SAMPLE_WIDTH-1:0] w_val   [0:WINDOW_MAX];
    logic                           w_keep  [0:WINDOW_MAX];
    logic                           w_run   [0:WINDOW_MAX];
    // front selection; cell j reads index j+1 and drives index j
    logic                           w_older [0:WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] w_sel   [0:WINDOW_MAX];

    // Clamp the window length to 1..WINDOW_MAX
    assign w_len = KW'(r_window_len);
    always_comb begin
        priority if (w_len == '0) begin
            w_k = KW'(1);
        end else if (w_len > K_MAX) begin
            w_k = K_MAX;
        end else begin
            w_k = w_len;
        end
    end

    // Handshake: take a sample unless a pending result cannot move on
    assign w_load_ok = ~r_out_valid | i_ready;
    assign w_load    = r_pend & w_load_ok;
    assign o_ready   = ~r_pend | w_load_ok;
    assign w_accept  = i_valid & o_ready;

    // Count samples since restart, saturating at WINDOW_MAX
    assign w_seen_base = i_restart ? '0 : r_seen;
    assign n_seen      = (w_seen_base == K_MAX) ? w_seen_base : w_seen_base + KW'(1);
    assign w_hit       = (n_seen >= w_k);

    // Feed the new sample into the young end of the chain
    assign w_val[0]  = i_sample;
    assign w_keep[0] = 1'b1;
    assign w_run[0]  = 1'b1;

    // Nothing is older than the last cell
    assign w_older[WINDOW_MAX] = 1'b0;
    assign w_sel[WINDOW_MAX]   = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swe_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .KW           (KW),
            .IDX          (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_accept),
            .i_restart    (i_restart),
            .i_mode       (r_mode),
            .i_k          (w_k),
            .i_sample     (i_sample),
            .i_prev_value (w_val[g]),
            .i_prev_alive (w_keep[g]),
            .i_run        (w_run[g]),
            .o_value      (w_val[g+1]),
            .o_keep       (w_keep[g+1]),
            .o_run        (w_run[g+1]),
            .i_older      (w_older[g+1]),
            .i_sel        (w_sel[g+1]),
            .o_older      (w_older[g]),
            .o_sel        (w_sel[g])
        );
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_W'(1);
            r_mode       <= MODE_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_LEN: r_window_len <= i_cfg_data[WINDOW_LEN_W-1:0];
                CFG_SELECT_MIN: r_mode       <= t_mode'(i_cfg_data[0]);
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    // Track sample count and a result owed from the updated chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_pend <= 1'b0;
        end else begin
            if (w_accept) begin
                r_seen <= n_seen;
                r_pend <= w_hit;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    // Output register: load the chain front, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_extreme <= w_sel[0];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_extreme = r_extreme;

endmodule
